[hdl/circular_fifo_with_search_update_assert.svh]
// assertion macros used by the checker file
`ifndef CIRCULAR_FIFO_WITH_SEARCH_UPDATE_ASSERT_SVH
`define CIRCULAR_FIFO_WITH_SEARCH_UPDATE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CFSU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfsu same-cycle check failed");

// next-cycle implication, checked outside reset
`define CFSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfsu next-cycle check failed");

`endif

[hdl/cfsu_pkg.sv]
// shared types and codes for the circular fifo with search and update
package cfsu_pkg;

   // operation codes
   localparam logic [2:0] OP_ENQUEUE = 3'd0;
   localparam logic [2:0] OP_DEQUEUE = 3'd1;
   localparam logic [2:0] OP_PEEK    = 3'd2;
   localparam logic [2:0] OP_SEARCH  = 3'd3;
   localparam logic [2:0] OP_UPDATE  = 3'd4;
   localparam logic [2:0] OP_CLEAR   = 3'd5;

   // width of the reported position and count fields
   localparam int RSP_CW = 5;

   typedef struct packed {
      logic [2:0]          opcode;
      logic signed [31:0]  value;
      logic signed [31:0]  old_value;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic signed [31:0]  data;
      logic [RSP_CW-1:0]   position;
      logic [RSP_CW-1:0]   count;
   } rsp_type;

   // what every cell does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_ROTATE,
      CELL_LOAD
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic signed [31:0]  load_data;
      logic signed [31:0]  wrap_data;
   } cell_ctl_type;

endpackage

[hdl/cfsu_cell.sv]
// one storage cell of the queue chain; cell k holds the k-th entry from the front
module cfsu_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 5
) (
   input  logic                  clock,
   input  cfsu_pkg::cell_ctl_type ctl,
   input  logic [CW-1:0]         count,
   input  logic signed [31:0]    next_data,
   output logic signed [31:0]    data
);
   import cfsu_pkg::*;

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;
   logic               is_last;
   logic               is_free_slot;

   // position of this cell relative to the fill level
   assign is_last      = (count == CW'(INDEX + 1));
   assign is_free_slot = (count == CW'(INDEX));

   // next word for this cell
   always_comb begin
      case (ctl.op)
         CELL_SHIFT:  data_in = next_data;
         CELL_ROTATE: data_in = is_last ? ctl.wrap_data : next_data;
         CELL_LOAD:   data_in = is_free_slot ? ctl.load_data : data_ff;
         default:     data_in = data_ff;
      endcase
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[hdl/cfsu_ctrl.sv]
// sequencer: decodes items, drives the cell chain and forms results
module cfsu_ctrl #(
   parameter int CAPACITY = 16,
   parameter int CW       = 5,
   parameter int IW       = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  cfsu_pkg::req_type      req_item,
   output logic                   busy,
   output logic                   rsp_valid,
   output cfsu_pkg::rsp_type      rsp_item,
   output cfsu_pkg::cell_ctl_type ctl,
   output logic [CW-1:0]          count,
   input  logic signed [31:0]     front_data
);
   import cfsu_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      step_ff, step_in;
   logic signed [31:0] key_ff, key_in;
   logic signed [31:0] repl_ff, repl_in;
   logic               is_update_ff, is_update_in;
   logic               found_ff, found_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               first_hit;
   logic [CW+RSP_CW-1:0] count_wide;
   logic [CW+RSP_CW-1:0] pos_wide;

   // first match seen at the front cell during a walk
   assign first_hit = (front_data == key_ff) && !found_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      key_in       = key_ff;
      repl_in      = repl_ff;
      is_update_in = is_update_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctl.op        = CELL_HOLD;
      ctl.load_data = req_item.value;
      ctl.wrap_data = front_data;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_valid_in    = 1'b1;
               rsp_in.ok       = 1'b0;
               rsp_in.data     = 32'sd0;
               rsp_in.position = '0;
               case (req_item.opcode)
                  OP_ENQUEUE: begin
                     if (count_ff != CW'(CAPACITY)) begin
                        ctl.op    = CELL_LOAD;
                        count_in  = count_ff + CW'(1);
                        rsp_in.ok = 1'b1;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (count_ff != '0) begin
                        ctl.op      = CELL_SHIFT;
                        count_in    = count_ff - CW'(1);
                        rsp_in.ok   = 1'b1;
                        rsp_in.data = front_data;
                     end
                  end
                  OP_PEEK: begin
                     if (count_ff != '0) begin
                        rsp_in.ok   = 1'b1;
                        rsp_in.data = front_data;
                     end
                  end
                  OP_SEARCH, OP_UPDATE: begin
                     // walk the chain only when something is stored
                     if (count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_WALK;
                        step_in      = '0;
                        is_update_in = (req_item.opcode == OP_UPDATE);
                        key_in       = (req_item.opcode == OP_UPDATE) ?
                                       req_item.old_value : req_item.value;
                        repl_in      = req_item.value;
                        found_in     = 1'b0;
                        pos_in       = '0;
                     end
                  end
                  OP_CLEAR: begin
                     count_in  = '0;
                     rsp_in.ok = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            // rotate the filled cells by one, front word wraps to the back
            ctl.op = CELL_ROTATE;
            if (first_hit) begin
               found_in = 1'b1;
               pos_in   = CW'(step_ff) + CW'(1);
               if (is_update_ff) begin
                  ctl.wrap_data = repl_ff;
               end
            end
            if (CW'(step_ff) == count_ff - CW'(1)) begin
               state_in        = ST_IDLE;
               rsp_valid_in    = 1'b1;
               rsp_in.ok       = found_in;
               rsp_in.data     = 32'sd0;
               rsp_in.position = '0;
            end else begin
               step_in = step_ff + IW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // report fields masked to the result width
      count_wide   = {{RSP_CW{1'b0}}, count_in};
      rsp_in.count = count_wide[RSP_CW-1:0];
      pos_wide     = {{RSP_CW{1'b0}}, pos_in};
      if ((state_ff == ST_WALK) && rsp_valid_in && !is_update_ff) begin
         rsp_in.position = pos_wide[RSP_CW-1:0];
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff      <= step_in;
      key_ff       <= key_in;
      repl_ff      <= repl_in;
      is_update_ff <= is_update_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff == ST_WALK);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign count     = count_ff;

endmodule

[hdl/circular_fifo_with_search_update.sv]
// Enqueue, dequeue, peek, clear and unknown opcodes: registered result in the
// cycle after the item is taken, and a new item may follow in the next cycle.
// Search and update rotate the filled cells once around the chain, one cell per
// cycle, with busy high during the walk and the result registered at its end.
// Synchronous reset empties the queue and drops any pending result; the stored
// words are not cleared. Results cannot be stalled by the receiver.
module circular_fifo_with_search_update #(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cfsu_pkg::req_type req_item,
   output logic              busy,
   output logic              rsp_valid,
   output cfsu_pkg::rsp_type rsp_item
);
   import cfsu_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   cell_ctl_type       ctl;
   logic [CW-1:0]      count;
   logic signed [31:0] cell_data [CAPACITY];

   // sequencer
   cfsu_ctrl #(
      .CAPACITY (CAPACITY),
      .CW       (CW),
      .IW       (IW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .ctl        (ctl),
      .count      (count),
      .front_data (cell_data[0])
   );

   // chain of cells, each fed by its back neighbor
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] next_word;
      if (i < CAPACITY - 1) begin : g_mid
         assign next_word = cell_data[i+1];
      end else begin : g_end
         assign next_word = 32'sd0;
      end
      cfsu_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .count     (count),
         .next_data (next_word),
         .data      (cell_data[i])
      );
   end

endmodule

[hdl/cfsu_checker.sv]
// port-level checks for the circular fifo, bound to the top level
`include "circular_fifo_with_search_update_assert.svh"

module cfsu_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input cfsu_pkg::req_type req_item,
   input logic              busy,
   input logic              rsp_valid,
   input cfsu_pkg::rsp_type rsp_item
);
   import cfsu_pkg::*;

   // items that need no walk answer in the next cycle
   `CFSU_ASSERT_NEXT(a_quick_result, clock, reset, start && !busy && req_item.opcode != OP_SEARCH && req_item.opcode != OP_UPDATE, rsp_valid)

   // end of a walk always brings its result
   `CFSU_ASSERT_IMPLY(a_walk_result, clock, reset, $fell(busy), rsp_valid)

   // no result while a walk is still running
   `CFSU_ASSERT_IMPLY(a_no_rsp_busy, clock, reset, rsp_valid, !busy)

   // a match position or a data word only comes with success
   `CFSU_ASSERT_IMPLY(a_ok_fields, clock, reset, rsp_valid && (rsp_item.position != '0 || rsp_item.data != 32'sd0), rsp_item.ok)

endmodule

bind circular_fifo_with_search_update cfsu_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .req_item  (req_item),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

[test/tb_circular_fifo_with_search_update.sv]
// testbench for the circular fifo with search and update
`timescale 1ns / 100ps

module tb_circular_fifo_with_search_update;
   import cfsu_pkg::*;

   localparam int CAPACITY      = 16;
   localparam int RANDOM_ITEMS  = 395;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int IDLE_PERCENT  = 17;
   // opcodes with no operation behind them
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct {
      req_type item;
      int      reps;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_item;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   // queue model state
   logic [31:0] ring_words [CAPACITY];
   int unsigned ring_head;
   int unsigned ring_tail;
   int unsigned ring_fill;

   rsp_type      pending_rsp_q [$];
   stim_row_type directed_rows [$];
   rsp_type      oldest_rsp;
   int           error_count;
   int           cycle_count;
   bit           idle_enabled;

   circular_fifo_with_search_update #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_item(req_item),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   // clock
   always #2 clock = ~clock;

   // run length guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("mismatch in %s at cycle %0d: expected %h, got %h",
               field, cycle_count, want, got);
      error_count++;
   endtask

   // apply one item to the queue model and return its result
   function automatic rsp_type fifo_apply(input req_type r);
      rsp_type     res;
      logic [31:0] key;
      int unsigned idx;
      int unsigned hit_pos;
      int unsigned hit_idx;
      res = '0;
      case (r.opcode)
         OP_ENQUEUE: begin
            if (ring_fill < CAPACITY) begin
               ring_words[ring_tail] = r.value;
               ring_tail = (ring_tail + 1) % CAPACITY;
               ring_fill++;
               res.ok = 1'b1;
            end
         end
         OP_DEQUEUE, OP_PEEK: begin
            if (ring_fill != 0) begin
               res.data = ring_words[ring_head];
               res.ok = 1'b1;
               if (r.opcode == OP_DEQUEUE) begin
                  ring_head = (ring_head + 1) % CAPACITY;
                  ring_fill--;
               end
            end
         end
         OP_SEARCH, OP_UPDATE: begin
            key = (r.opcode == OP_SEARCH) ? r.value : r.old_value;
            hit_pos = 0;
            hit_idx = 0;
            idx = ring_head;
            for (int i = 0; i < ring_fill; i++) begin
               if (hit_pos == 0 && ring_words[idx] == key) begin
                  hit_pos = i + 1;
                  hit_idx = idx;
               end
               idx = (idx + 1) % CAPACITY;
            end
            if (hit_pos != 0) begin
               res.ok = 1'b1;
               if (r.opcode == OP_SEARCH)
                  res.position = hit_pos[RSP_CW-1:0];
               else
                  ring_words[hit_idx] = r.value;
            end
         end
         OP_CLEAR: begin
            ring_head = 0;
            ring_tail = 0;
            ring_fill = 0;
            res.ok = 1'b1;
         end
         default: ;
      endcase
      res.count = ring_fill[RSP_CW-1:0];
      return res;
   endfunction

   // word source with frequent repeats and corner values
   function automatic logic [31:0] pick_word();
      if ($urandom_range(99) < 40) begin
         case ($urandom_range(5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h0000_0001;
            default: return 32'h1234_5678;
         endcase
      end
      return $urandom;
   endfunction

   // a word currently held, or a random one when empty
   function automatic logic [31:0] held_word();
      if (ring_fill == 0)
         return pick_word();
      return ring_words[(ring_head + $urandom_range(ring_fill - 1)) % CAPACITY];
   endfunction

   function automatic req_type make_random_req(input bit fill_phase);
      req_type     r;
      int unsigned roll;
      int unsigned enq_cut;
      int unsigned deq_cut;
      r.value = pick_word();
      r.old_value = $urandom;
      enq_cut = fill_phase ? 45 : 22;
      deq_cut = enq_cut + (fill_phase ? 15 : 38);
      roll = $urandom_range(99);
      if (roll < enq_cut)
         r.opcode = OP_ENQUEUE;
      else if (roll < deq_cut)
         r.opcode = OP_DEQUEUE;
      else if (roll < deq_cut + 8)
         r.opcode = OP_PEEK;
      else if (roll < deq_cut + 20)
         r.opcode = OP_SEARCH;
      else if (roll < deq_cut + 32)
         r.opcode = OP_UPDATE;
      else if (roll < 97)
         r.opcode = OP_CLEAR;
      else
         r.opcode = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
      // aim searches and updates at held words most of the time
      if (r.opcode == OP_SEARCH && $urandom_range(99) < 65)
         r.value = held_word();
      if (r.opcode == OP_UPDATE && $urandom_range(99) < 65)
         r.old_value = held_word();
      return r;
   endfunction

   task automatic add_row(input logic [2:0] op, input logic [31:0] value,
                          input logic [31:0] old_value, input int reps, input bit typed,
                          input int ok, input logic [31:0] data,
                          input int position, input int count);
      stim_row_type row;
      row.item.opcode = op;
      row.item.value = value;
      row.item.old_value = old_value;
      row.reps = reps;
      row.typed = typed;
      row.want.ok = ok[0];
      row.want.data = data;
      row.want.position = position[RSP_CW-1:0];
      row.want.count = count[RSP_CW-1:0];
      directed_rows.push_back(row);
   endtask

   // hand one item to the block and record what it should give back
   task automatic send_item(input req_type r, input bit typed, input rsp_type want);
      rsp_type predicted;
      if (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
         start <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      predicted = fifo_apply(r);
      pending_rsp_q.push_back(typed ? want : predicted);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_item.data);
         end else begin
            oldest_rsp = pending_rsp_q.pop_front();
            if (rsp_item.ok !== oldest_rsp.ok)
               report_mismatch("ok", 32'(oldest_rsp.ok), 32'(rsp_item.ok));
            if (rsp_item.data !== oldest_rsp.data)
               report_mismatch("data", oldest_rsp.data, rsp_item.data);
            if (rsp_item.position !== oldest_rsp.position)
               report_mismatch("position", 32'(oldest_rsp.position),
                               32'(rsp_item.position));
            if (rsp_item.count !== oldest_rsp.count)
               report_mismatch("count", 32'(oldest_rsp.count), 32'(rsp_item.count));
         end
      end
   end

   // stimulus
   initial begin
      req_type r;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      error_count = 0;
      cycle_count = 0;
      idle_enabled = 1'b1;
      ring_head = 0;
      ring_tail = 0;
      ring_fill = 0;

      // empty queue, spare opcodes, extremes, full queue, wrap of both pointers
      add_row(OP_DEQUEUE, 32'h0, 32'h0, 1, 1, 0, 32'h0, 0, 0);
      add_row(OP_PEEK,    32'h0, 32'h0, 1, 1, 0, 32'h0, 0, 0);
      add_row(OP_SEARCH,  32'h0, 32'h0, 1, 1, 0, 32'h0, 0, 0);
      add_row(OP_UPDATE,  32'h1, 32'h0, 1, 1, 0, 32'h0, 0, 0);
      add_row(OP_SPARE_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0, 32'h0, 0, 0);
      add_row(OP_SPARE_7, 32'h0, 32'h0, 1, 1, 0, 32'h0, 0, 0);
      add_row(OP_ENQUEUE, 32'h7FFF_FFFF, 32'h0, 1, 1, 1, 32'h0, 0, 1);
      add_row(OP_ENQUEUE, 32'h8000_0000, 32'h0, 1, 1, 1, 32'h0, 0, 2);
      add_row(OP_ENQUEUE, 32'hFFFF_FFFF, 32'h0, 1, 1, 1, 32'h0, 0, 3);
      add_row(OP_ENQUEUE, 32'h0, 32'h0, 1, 1, 1, 32'h0, 0, 4);
      add_row(OP_ENQUEUE, 32'h5555_5555, 32'h0, 12, 0, 0, 32'h0, 0, 0);
      add_row(OP_ENQUEUE, 32'h1, 32'h0, 1, 1, 0, 32'h0, 0, 16);
      add_row(OP_SEARCH,  32'h8000_0000, 32'h0, 1, 1, 1, 32'h0, 2, 16);
      add_row(OP_SEARCH,  32'h5555_5560, 32'h0, 1, 0, 0, 32'h0, 0, 0);
      add_row(OP_SEARCH,  32'd12345, 32'h0, 1, 1, 0, 32'h0, 0, 16);
      add_row(OP_UPDATE,  32'hAAAA_AAAA, 32'h0, 1, 1, 1, 32'h0, 0, 16);
      add_row(OP_UPDATE,  32'h2, 32'd12345, 1, 1, 0, 32'h0, 0, 16);
      add_row(OP_PEEK,    32'h0, 32'h0, 1, 1, 1, 32'h7FFF_FFFF, 0, 16);
      add_row(OP_DEQUEUE, 32'h0, 32'h0, 1, 1, 1, 32'h7FFF_FFFF, 0, 15);
      add_row(OP_ENQUEUE, 32'hFFFF_FFFF, 32'h0, 1, 0, 0, 32'h0, 0, 0);
      // only the first of two equal words is replaced
      add_row(OP_UPDATE,  32'h5, 32'hFFFF_FFFF, 1, 0, 0, 32'h0, 0, 0);
      add_row(OP_SEARCH,  32'hFFFF_FFFF, 32'h0, 1, 0, 0, 32'h0, 0, 0);
      add_row(OP_SPARE_6, 32'h0, 32'h0, 1, 0, 0, 32'h0, 0, 0);
      add_row(OP_DEQUEUE, 32'h0, 32'h0, 16, 0, 0, 32'h0, 0, 0);
      add_row(OP_ENQUEUE, 32'h3, 32'h0, 3, 0, 0, 32'h0, 0, 0);
      add_row(OP_CLEAR,   32'h0, 32'h0, 1, 1, 1, 32'h0, 0, 0);
      // stale words after a clear must not match
      add_row(OP_SEARCH,  32'h3, 32'h0, 1, 1, 0, 32'h0, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[n]) begin
         for (int k = 0; k < directed_rows[n].reps; k++) begin
            r = directed_rows[n].item;
            r.value = r.value + k;
            send_item(r, directed_rows[n].typed, directed_rows[n].want);
         end
      end

      // let the queue settle before the random part
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // a long run with no gaps in the middle
         idle_enabled = !(n >= 200 && n < 300);
         if (n == 320)
            drain_results();
         r = make_random_req(((n / 60) % 2) == 0);
         send_item(r, 1'b0, '0);
      end

      drain_results();
      repeat (CAPACITY + 4) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
